// ===== rtl/b64d_pkg.sv =====
// Shared types and constants for the base64 stream decoder.
`timescale 1ns / 1ps
`default_nettype none
package b64d_pkg;

  localparam int unsigned CharW   = 8;
  localparam int unsigned SextetW = 6;
  localparam int unsigned StoreW  = 12;
  localparam int unsigned HeldW   = 4;
  localparam int unsigned MaxW    = 28;
  localparam int unsigned CharsW  = MaxW + 1;

  localparam logic [MaxW-1:0] MAX_BYTES_RESET = 28'd67108864;

  typedef enum logic [1:0] {
    KIND_SEXTET = 2'd0,
    KIND_SKIP   = 2'd1,
    KIND_PAD    = 2'd2,
    KIND_BAD    = 2'd3
  } char_kind_t;

  typedef struct packed {
    char_kind_t         kind;
    logic [SextetW-1:0] value;
  } char_class_t;

  typedef struct packed {
    logic             has_result;
    logic             byte_valid;
    logic [CharW-1:0] data_byte;
    logic             stream_end;
    logic             stream_ok;
  } result_t;

endpackage
`default_nettype wire

// ===== rtl/b64d_classify.sv =====
// Character classifier: maps one ASCII code to a base64 kind and 6-bit value.
`timescale 1ns / 1ps
`default_nettype none
module b64d_classify
  import b64d_pkg::*;
(
  input  wire logic [CharW-1:0] char_code,
  output char_class_t           char_class
);

  localparam logic [CharW-1:0] ChUpperA = 8'h41;
  localparam logic [CharW-1:0] ChUpperZ = 8'h5A;
  localparam logic [CharW-1:0] ChLowerA = 8'h61;
  localparam logic [CharW-1:0] ChLowerZ = 8'h7A;
  localparam logic [CharW-1:0] ChZero   = 8'h30;
  localparam logic [CharW-1:0] ChNine   = 8'h39;
  localparam logic [CharW-1:0] ChPlus   = 8'h2B;
  localparam logic [CharW-1:0] ChSlash  = 8'h2F;
  localparam logic [CharW-1:0] ChEqual  = 8'h3D;
  localparam logic [CharW-1:0] ChCr     = 8'h0D;
  localparam logic [CharW-1:0] ChLf     = 8'h0A;
  localparam logic [CharW-1:0] ChSpace  = 8'h20;
  localparam logic [CharW-1:0] ChTab    = 8'h09;

  localparam logic [CharW-1:0] OffLower = 8'd71;  // 'a' - 26
  localparam logic [CharW-1:0] OffDigit = 8'd252; // '0' - 52, mod 256

  logic [CharW-1:0] diff;

  always_comb begin
    diff             = '0;
    char_class.kind  = KIND_BAD;
    char_class.value = '0;
    case (char_code) inside
      [ChUpperA:ChUpperZ]: begin
        diff             = char_code - ChUpperA;
        char_class.kind  = KIND_SEXTET;
        char_class.value = diff[SextetW-1:0];
      end
      [ChLowerA:ChLowerZ]: begin
        diff             = char_code - OffLower;
        char_class.kind  = KIND_SEXTET;
        char_class.value = diff[SextetW-1:0];
      end
      [ChZero:ChNine]: begin
        diff             = char_code - OffDigit;
        char_class.kind  = KIND_SEXTET;
        char_class.value = diff[SextetW-1:0];
      end
      ChPlus: begin
        char_class.kind  = KIND_SEXTET;
        char_class.value = 6'd62;
      end
      ChSlash: begin
        char_class.kind  = KIND_SEXTET;
        char_class.value = 6'd63;
      end
      ChEqual: begin
        char_class.kind = KIND_PAD;
      end
      ChCr, ChLf, ChSpace, ChTab: begin
        char_class.kind = KIND_SKIP;
      end
      default: begin
        char_class.kind = KIND_BAD;
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/b64d_core.sv =====
// Decode state: bit store, counters, pad and error flags, and the per-character step.
`timescale 1ns / 1ps
`default_nettype none
module b64d_core
  import b64d_pkg::*;
(
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            step,
  input  char_class_t          char_class,
  input  wire logic            last_char,
  input  wire logic [MaxW-1:0] max_bytes,
  output result_t              result
);

  logic [StoreW-1:0] store_r, store_nxt;
  logic [HeldW-1:0]  held_r, held_nxt;
  logic              pad_r, pad_nxt;
  logic              err_r, err_nxt;
  logic [MaxW-1:0]   bytes_r, bytes_nxt;
  logic [CharsW-1:0] chars_r, chars_nxt;

  logic [StoreW-1:0] packed_bits;
  logic [HeldW-1:0]  held_sum;
  logic [HeldW-1:0]  held_left;
  logic [CharW-1:0]  byte_val;
  logic              have_byte;

  always_comb begin
    chars_nxt   = (chars_r == '1) ? chars_r : chars_r + 1'b1;
    store_nxt   = store_r;
    held_nxt    = held_r;
    pad_nxt     = pad_r;
    bytes_nxt   = bytes_r;
    err_nxt     = err_r | (chars_nxt > {max_bytes, 1'b0});
    packed_bits = {store_r[SextetW-1:0], char_class.value};
    held_sum    = held_r + HeldW'(SextetW);
    held_left   = held_sum - HeldW'(CharW);
    byte_val    = '0;
    have_byte   = 1'b0;

    if (!err_nxt) begin
      case (char_class.kind)
        KIND_PAD:  pad_nxt = 1'b1;
        KIND_SKIP: ;
        KIND_BAD:  err_nxt = 1'b1;
        KIND_SEXTET: begin
          if (pad_r) begin
            err_nxt = 1'b1;
          end else if (held_sum >= HeldW'(CharW)) begin
            held_nxt = held_left;
            // held count is always even and at most four after a byte leaves
            case (held_left)
              4'd2: begin
                byte_val  = packed_bits[9:2];
                store_nxt = {10'd0, packed_bits[1:0]};
              end
              4'd4: begin
                byte_val  = packed_bits[11:4];
                store_nxt = {8'd0, packed_bits[3:0]};
              end
              default: begin
                byte_val  = packed_bits[7:0];
                store_nxt = '0;
              end
            endcase
            if (bytes_r >= max_bytes) begin
              err_nxt = 1'b1;
            end else begin
              bytes_nxt = bytes_r + 1'b1;
              have_byte = 1'b1;
            end
          end else begin
            store_nxt = packed_bits;
            held_nxt  = held_sum;
          end
        end
        default: err_nxt = 1'b1;
      endcase
    end

    result.has_result = have_byte | last_char;
    result.byte_valid = have_byte;
    result.data_byte  = have_byte ? byte_val : '0;
    result.stream_end = last_char;
    result.stream_ok  = last_char & ~err_nxt & (bytes_nxt != '0);

    if (last_char) begin
      store_nxt = '0;
      held_nxt  = '0;
      pad_nxt   = 1'b0;
      err_nxt   = 1'b0;
      bytes_nxt = '0;
      chars_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      store_r <= '0;
      held_r  <= '0;
      pad_r   <= 1'b0;
      err_r   <= 1'b0;
      bytes_r <= '0;
      chars_r <= '0;
    end else if (step) begin
      store_r <= store_nxt;
      held_r  <= held_nxt;
      pad_r   <= pad_nxt;
      err_r   <= err_nxt;
      bytes_r <= bytes_nxt;
      chars_r <= chars_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/base64_stream_decoder.sv =====
// Top level of the base64 stream decoder: channel registers, config register, assertions.
//
// Usage:
//   in_*  : one ASCII character per transaction in in_tdata, in_tlast on the
//           final character of an encoded text.
//   out_* : at most one transaction per character. out_tuser marks a decoded
//           byte in out_tdata[7:0]; out_tlast marks the end of a text, with
//           out_tdata[8] high when the text decoded without error into at
//           least one byte. Characters that yield neither give no transaction.
//   cfg_* : writes max_bytes; always ready. Write only while the block is idle.
// Path: an accepted character waits in the input register, and its result is
//   loaded into the output register when the decode step advances.
// Throughput: one character per cycle while the output is not stalled, set by
//   the decode step between the input register and the output register.
// Reset: both registers empty, decode state cleared, max_bytes = 2**26.
//   No clearing pass is needed.
// Stall: while out_tready is low and a result waits, the input register
//   holds its character and in_tready drops once it is full.
`timescale 1ns / 1ps
`default_nettype none
module base64_stream_decoder
  import b64d_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  // input channel
  input  wire logic             in_tvalid,
  output logic                  in_tready,
  input  wire logic [7:0]       in_tdata,  // [7:0] char_code
  input  wire logic             in_tlast,  // last_char
  // result channel
  output logic                  out_tvalid,
  input  wire logic             out_tready,
  output logic [15:0]           out_tdata, // [7:0] data_byte, [8] stream_ok, rest zero
  output logic                  out_tuser, // [0] byte_valid
  output logic                  out_tlast, // stream_end
  // configuration
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic [MaxW-1:0]  cfg_data   // max_bytes
);

  logic              in_valid_r;
  logic [CharW-1:0]  in_char_r;
  logic              in_last_r;
  logic              out_valid_r;
  logic [CharW-1:0]  out_byte_r;
  logic              out_ok_r;
  logic              out_user_r;
  logic              out_last_r;
  logic [MaxW-1:0]   max_bytes_r;

  logic              advance;
  char_class_t       char_class;
  result_t           result;

  // Move the held character through the decode step whenever the output
  // register is free or is being drained this cycle.
  assign advance   = in_valid_r & (~out_valid_r | out_tready);
  assign in_tready = ~in_valid_r | advance;
  assign cfg_ready = 1'b1;

  b64d_classify u_classify (
    .char_code  (in_char_r),
    .char_class (char_class)
  );

  b64d_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (advance),
    .char_class (char_class),
    .last_char  (in_last_r),
    .max_bytes  (max_bytes_r),
    .result     (result)
  );

  // Input register: capture a character on each input transaction.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_char_r <= in_tdata;
      in_last_r <= in_tlast;
    end
  end

  // Output register: load a result, or drop valid once it is taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= result.has_result;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_byte_r <= result.data_byte;
      out_ok_r   <= result.stream_ok;
      out_user_r <= result.byte_valid;
      out_last_r <= result.stream_end;
    end
  end

  // Configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_bytes_r <= MAX_BYTES_RESET;
    end else if (cfg_valid && cfg_ready) begin
      max_bytes_r <= cfg_data;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_ok_r, out_byte_r};
  assign out_tuser  = out_user_r;
  assign out_tlast  = out_last_r;

  // A result with no decoded byte exists only to close a text.
  a_nobyte_is_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser) |-> out_tlast)
    else $error("result without byte and without stream end");

  // Success is reported only at the end of a text.
  a_ok_only_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tlast) |-> !out_tdata[8])
    else $error("stream_ok set before stream end");

  // The byte field reads zero whenever a result carries no decoded byte.
  a_byte_zero_when_absent: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser) |-> (out_tdata[7:0] == 8'd0))
    else $error("data_byte nonzero without byte_valid");

  // A held result is not overwritten while the receiver stalls.
  a_stall_no_advance: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready) |-> !advance)
    else $error("decode step advanced into a stalled output register");

endmodule
`default_nettype wire

// ===== verif/base64_stream_decoder_test.sv =====
// Self-checking testbench for the base64 stream decoder: directed table plus random streams.
`timescale 1ns / 1ps
`default_nettype none
module base64_stream_decoder_test;
  import b64d_pkg::*;

  // Character codes with a meaning of their own.
  localparam logic [7:0] CH_PAD = 8'h3D;  // '='
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_SP  = 8'h20;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_UPPER_A = 8'h41;  // 'A'
  localparam logic [7:0] CH_LOWER_A = 8'h61;  // 'a'
  localparam logic [7:0] CH_DIGIT_0 = 8'h30;  // '0'
  localparam logic [7:0] CH_PLUS    = 8'h2B;  // '+'
  localparam logic [7:0] CH_SLASH   = 8'h2F;  // '/'
  localparam int unsigned SEXTET_LOWER = 26;
  localparam int unsigned SEXTET_DIGIT = 52;
  localparam int unsigned SEXTET_PLUS  = 62;
  localparam int unsigned SEXTET_SLASH = 63;

  // Cycle counts: hold-off before a register write, tail at the end, watchdog.
  localparam int DRAIN_CYCLES   = 4;
  localparam int END_CYCLES     = 8;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int IDLE_PERCENT   = 27;

  // One row of the directed table: either a register write or a character.
  typedef struct packed {
    logic            is_cfg;
    logic [MaxW-1:0] limit;
    logic [7:0]      ch;
    logic            last;
    logic            typed;   // exp holds a hand-written result for this row
    result_t         exp;
  } dir_row_t;

  logic             clk;
  logic             rst_n      = 1'b0;
  logic             in_tvalid  = 1'b0;
  logic             in_tready;
  logic [7:0]       in_tdata   = 8'h00;
  logic             in_tlast   = 1'b0;
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [15:0]      out_tdata;
  logic             out_tuser;
  logic             out_tlast;
  logic             cfg_valid  = 1'b0;
  logic             cfg_ready;
  logic [MaxW-1:0]  cfg_data   = '0;

  // Decoder model state, a copy of what the block holds.
  logic [MaxW-1:0]   byte_limit;
  logic [StoreW-1:0] pend_bits;
  logic [HeldW-1:0]  pend_count;
  logic              pad_flag;
  logic              err_flag;
  logic [MaxW-1:0]   byte_count;
  logic [CharsW-1:0] char_count;

  result_t   decoded_results [$];  // results still owed by the block, oldest first
  dir_row_t  dir_rows [$];
  result_t   oldest;
  bit        steady = 1'b0;        // no idling on either side while set
  int        mismatches = 0;
  int        chars_sent = 0;
  int        results_seen = 0;
  int        ends_seen = 0;
  int        cfg_writes = 0;
  int        quiet_cycles = 0;

  base64_stream_decoder dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),    // [7:0] char_code
    .in_tlast   (in_tlast),    // last_char
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),   // [7:0] data_byte, [8] stream_ok, rest zero
    .out_tuser  (out_tuser),   // [0] byte_valid
    .out_tlast  (out_tlast),   // stream_end
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)     // max_bytes
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Clear everything that belongs to one encoded text; the byte limit stays.
  function automatic void clear_text();
    pend_bits  = '0;
    pend_count = '0;
    pad_flag   = 1'b0;
    err_flag   = 1'b0;
    byte_count = '0;
    char_count = '0;
  endfunction

  // Sort one character into sextet, whitespace, padding or unknown.
  function automatic char_class_t classify(input logic [7:0] ch);
    char_class_t cls;
    cls.kind  = KIND_SEXTET;
    cls.value = '0;
    if (ch >= CH_UPPER_A && ch <= CH_UPPER_A + 8'd25) begin
      cls.value = 6'(ch - CH_UPPER_A);
    end else if (ch >= CH_LOWER_A && ch <= CH_LOWER_A + 8'd25) begin
      cls.value = 6'(ch - CH_LOWER_A + SEXTET_LOWER);
    end else if (ch >= CH_DIGIT_0 && ch <= CH_DIGIT_0 + 8'd9) begin
      cls.value = 6'(ch - CH_DIGIT_0 + SEXTET_DIGIT);
    end else if (ch == CH_PLUS) begin
      cls.value = 6'(SEXTET_PLUS);
    end else if (ch == CH_SLASH) begin
      cls.value = 6'(SEXTET_SLASH);
    end else if (ch == CH_PAD) begin
      cls.kind = KIND_PAD;
    end else if (ch == CH_CR || ch == CH_LF || ch == CH_SP || ch == CH_TAB) begin
      cls.kind = KIND_SKIP;
    end else begin
      cls.kind = KIND_BAD;
    end
    return cls;
  endfunction

  // Advance the decoder model by one character and return what it owes.
  function automatic result_t decode_char(input logic [7:0] ch, input logic last);
    char_class_t       cls;
    logic              have;
    logic [7:0]        got_byte;
    logic [StoreW-1:0] shifted;
    result_t           r;
    have     = 1'b0;
    got_byte = '0;
    cls      = classify(ch);
    // Every character counts toward the limit, skipped ones and padding too.
    if (char_count != '1) char_count = char_count + 1'b1;
    if ({1'b0, char_count} > {1'b0, byte_limit, 1'b0}) err_flag = 1'b1;
    if (!err_flag) begin
      case (cls.kind)
        KIND_PAD:  pad_flag = 1'b1;
        KIND_SKIP: ;
        KIND_BAD:  err_flag = 1'b1;
        default: begin
          if (pad_flag) begin
            err_flag = 1'b1;
          end else begin
            pend_bits  = {pend_bits[StoreW-SextetW-1:0], cls.value};
            pend_count = pend_count + 4'd6;
            if (pend_count >= 4'd8) begin
              pend_count = pend_count - 4'd8;
              shifted    = pend_bits >> pend_count;
              got_byte   = shifted[7:0];
              pend_bits  = pend_bits & ((12'd1 << pend_count) - 12'd1);
              // A byte past the limit is dropped and flags the text instead.
              if ({1'b0, byte_count} + 1'b1 > {1'b0, byte_limit}) begin
                err_flag = 1'b1;
              end else begin
                byte_count = byte_count + 1'b1;
                have       = 1'b1;
              end
            end
          end
        end
      endcase
    end
    r.has_result = have || last;
    r.byte_valid = have;
    r.data_byte  = have ? got_byte : 8'h00;
    r.stream_end = last;
    r.stream_ok  = last && !err_flag && byte_count != '0;
    if (last) clear_text();
    return r;
  endfunction

  function automatic logic [7:0] sextet_char(input int unsigned v);
    if (v < SEXTET_LOWER) return 8'(CH_UPPER_A + v);
    if (v < SEXTET_DIGIT) return 8'(CH_LOWER_A + v - SEXTET_LOWER);
    if (v < SEXTET_PLUS) return 8'(CH_DIGIT_0 + v - SEXTET_DIGIT);
    if (v == SEXTET_PLUS) return CH_PLUS;
    return CH_SLASH;
  endfunction

  task automatic report_mismatch(input string field, input logic [15:0] got,
                                 input logic [15:0] want);
    $display("ERROR at %0t: %s got 0x%0h, want 0x%0h", $time, field, got, want);
    mismatches++;
  endtask

  // Append one row at the tail of the directed table.
  task automatic add_row(input dir_row_t row);
    dir_rows.insert(dir_rows.size(), row);
  endtask

  // Table rows: a plain character, a character with a typed result, a register write.
  task automatic row_char(input logic [7:0] ch);
    add_row(dir_row_t'{1'b0, '0, ch, 1'b0, 1'b0, result_t'(0)});
  endtask

  task automatic row_end(input logic [7:0] ch, input logic bv, input logic [7:0] data,
                         input logic ok);
    add_row(dir_row_t'{1'b0, '0, ch, 1'b1, 1'b1, result_t'{1'b1, bv, data, 1'b1, ok}});
  endtask

  task automatic row_limit(input logic [MaxW-1:0] value);
    add_row(dir_row_t'{1'b1, value, 8'h00, 1'b0, 1'b0, result_t'(0)});
  endtask

  // Offer one character, hold it until accepted, then book the result it owes.
  task automatic send_char(input logic [7:0] ch, input logic last, input logic typed,
                           input result_t fixed);
    result_t owed;
    while (!steady && $urandom_range(99) < IDLE_PERCENT) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= ch;
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    owed = decode_char(ch, last);
    if (typed) owed = fixed;
    if (owed.has_result) decoded_results.insert(decoded_results.size(), owed);
    chars_sent++;
  endtask

  // Write max_bytes only once the block has gone quiet.
  task automatic write_limit(input logic [MaxW-1:0] value);
    in_tvalid <= 1'b0;
    while (decoded_results.size() != 0) @(posedge clk);
    // Characters that owe nothing may still be in flight.
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    byte_limit = value;
    cfg_writes++;
    cfg_valid <= 1'b0;
  endtask

  // One random text: mostly well-formed base64, sometimes broken or noisy.
  task automatic send_stream();
    int unsigned n;
    int unsigned pads;
    logic        broken;
    logic [7:0]  ch;
    n      = ($urandom_range(9) == 0) ? $urandom_range(48, 21) : $urandom_range(20, 1);
    broken = ($urandom_range(99) < 20);
    pads   = broken ? 0 : $urandom_range(2);
    for (int unsigned i = 0; i < n; i++) begin
      if (broken && $urandom_range(7) == 0) begin
        ch = 8'($urandom_range(255));
      end else if (broken && $urandom_range(15) == 0) begin
        ch = CH_PAD;
      end else if (n > 2 && i + pads >= n) begin
        ch = CH_PAD;
      end else if ($urandom_range(99) < 8) begin
        case ($urandom_range(3))
          0:       ch = CH_CR;
          1:       ch = CH_LF;
          2:       ch = CH_SP;
          default: ch = CH_TAB;
        endcase
      end else begin
        ch = sextet_char($urandom_range(63));
      end
      send_char(ch, i == n - 1, 1'b0, result_t'(0));
    end
  endtask

  // Receiver side: stall at random unless a steady stretch is running.
  always @(posedge clk) begin
    out_tready <= steady || ($urandom_range(99) >= IDLE_PERCENT);
  end

  // Compare every result transaction with the oldest booked result.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      if (out_tlast) ends_seen++;
      if (decoded_results.size() == 0) begin
        report_mismatch("result with nothing owed, tdata", out_tdata, 16'h0000);
      end else begin
        oldest = decoded_results.pop_front();
        if (out_tuser !== oldest.byte_valid)
          report_mismatch("byte_valid", 16'(out_tuser), 16'(oldest.byte_valid));
        if (out_tdata[7:0] !== oldest.data_byte)
          report_mismatch("data_byte", 16'(out_tdata[7:0]), 16'(oldest.data_byte));
        if (out_tlast !== oldest.stream_end)
          report_mismatch("stream_end", 16'(out_tlast), 16'(oldest.stream_end));
        if (out_tdata[8] !== oldest.stream_ok)
          report_mismatch("stream_ok", 16'(out_tdata[8]), 16'(oldest.stream_ok));
        if (out_tdata[15:9] !== 7'd0)
          report_mismatch("tdata upper bits", 16'(out_tdata[15:9]), 16'h0000);
      end
    end
  end

  // Watchdog: end the run when no channel moves a transaction for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("Timeout: %0d results still owed", decoded_results.size());
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic [MaxW-1:0] limit_val;
    int              budget;
    int              start;
    byte_limit = MAX_BYTES_RESET;
    clear_text();

    // The three highest sextet codes, all four whitespace codes, padded end.
    row_char(CH_SLASH);
    row_char(CH_PLUS);
    row_char("9");
    row_char(CH_SP);
    row_char(CH_TAB);
    row_char(CH_CR);
    row_char(CH_LF);
    row_end(CH_PAD, 1'b0, 8'h00, 1'b1);
    // Data after padding fails the text.
    row_char("Q");
    row_char("U");
    row_char(CH_PAD);
    row_end("B", 1'b0, 8'h00, 1'b0);
    // Top unknown code mid-text, then the zero code alone on the last character.
    row_char(8'hFF);
    row_end("Q", 1'b0, 8'h00, 1'b0);
    row_end(8'h00, 1'b0, 8'h00, 1'b0);
    // Leftover bits are dropped, so no byte and no success.
    row_end("A", 1'b0, 8'h00, 1'b0);
    // Limit of one: one byte together with the end.
    row_limit(28'd1);
    row_char("Q");
    row_end("U", 1'b1, 8'h41, 1'b1);
    // Byte limit hit before the character limit.
    row_limit(28'd3);
    row_char("Q");
    row_char("U");
    row_char("J");
    row_char("D");
    row_char("R");
    row_end("E", 1'b0, 8'h00, 1'b0);
    // Zero limit: the first character already breaks the character limit.
    row_limit(28'd0);
    row_end("Q", 1'b0, 8'h00, 1'b0);

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg) begin
        write_limit(dir_rows[i].limit);
      end else begin
        send_char(dir_rows[i].ch, dir_rows[i].last, dir_rows[i].typed, dir_rows[i].exp);
      end
    end

    // Random texts under a range of limits, from zero to all ones.
    for (int p = 0; p < 8; p++) begin
      case (p)
        0:       limit_val = MAX_BYTES_RESET;
        1:       limit_val = MaxW'($urandom_range(8, 1));
        2:       limit_val = 28'h8000000;
        3:       limit_val = MaxW'($urandom_range(40, 9));
        4:       limit_val = 28'hFFFFFFF;
        5:       limit_val = 28'd1;
        6:       limit_val = 28'd0;
        default: limit_val = MaxW'($urandom_range(4, 1));
      endcase
      write_limit(limit_val);
      steady = (p == 0);
      budget = (p == 6) ? 20 : 50;
      start  = chars_sent;
      while (chars_sent - start < budget) send_stream();
    end
    steady = 1'b0;

    // Drain: wait for every owed result, then a tail for strays.
    in_tvalid <= 1'b0;
    while (decoded_results.size() != 0) @(posedge clk);
    repeat (END_CYCLES) @(posedge clk);

    $display("Sent %0d characters under %0d limit writes; checked %0d results, %0d ends",
             chars_sent, cfg_writes, results_seen, ends_seen);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("%0d field errors", mismatches);
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
`default_nettype wire
